FILE: src/dlx_pkg.sv
// Shared types and constants for the dual-LCG XOR stream cipher.
package dlx_pkg;

    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned KLEN_W    = 6;
    localparam int unsigned POS_W     = 64;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [KLEN_W-1:0]    KEY_MIN_LEN  = 6'd4;
    localparam logic [CNT_W-1:0]     POS_MSB      = 6'd63;
    localparam logic [CNT_W-1:0]     MIX_LAST     = 6'd3;

    localparam logic [31:0] FNV_BASIS   = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME   = 32'h01000193;
    localparam logic [31:0] DJB_BASIS   = 32'h00001505;
    localparam logic [31:0] LCG_A_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_A_INC   = 32'd1013904223;
    localparam logic [31:0] LCG_B_MUL   = 32'd22695477;
    localparam logic [31:0] LCG_B_INC   = 32'd1;
    localparam logic [31:0] GOLDEN      = 32'h9E3779B9;
    localparam logic [31:0] SEED_A_ALT  = 32'h12345678;
    localparam logic [31:0] SEED_B_ALT  = 32'h9ABCDEF0;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_BAD_KEY = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    typedef struct packed {
        logic       op;
        logic [7:0] data_in;
        logic       last_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]       data_out;
        logic             status;
        logic [POS_W-1:0] stream_position;
        logic             last_out;
    } t_out_beat;

    typedef struct packed {
        logic             load_in;
        logic             set_err;
        logic             seed_init;
        logic             seed_step;
        logic             mix_step;
        logic             mix_last;
        logic             mod_init;
        logic             mod_step;
        logic             mod_last;
        logic             byte_step;
        logic             out_load;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic              key_ok;
        logic [KLEN_W-1:0] key_len;
        logic              kidx_stale;
    } t_dp_sts;

    function automatic logic [7:0] key_byte(input t_key k, input logic [4:0] i);
        return k[i[4:3]][{i[2:0], 3'b000} +: 8];
    endfunction

endpackage

FILE: src/dlx_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface dlx_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/dlx_ctrl.sv
// Controller state machine sequencing restart, key-index recovery and data beats.
module dlx_ctrl
    import dlx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_MIX,
        S_MOD,
        S_BYTE,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;
    logic             in_ready;
    logic             accept;
    t_dp_cmd          cmd;

    always_comb begin
        slot_free   = !r_out_valid || i_out_ready;
        in_ready    = (r_state == S_IDLE) || ((r_state == S_DONE) && slot_free);
        accept      = i_in_valid && in_ready;
        cmd         = '0;
        cmd.idx     = r_cnt;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_SEED: begin
                cmd.seed_step = 1'b1;
                if (r_cnt == i_sts.key_len - 6'd1) begin
                    n_state = S_MIX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_MIX: begin
                if (r_cnt == MIX_LAST) begin
                    cmd.mix_last = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    cmd.mix_step = 1'b1;
                    n_cnt        = r_cnt + 6'd1;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                if (r_cnt == '0) begin
                    cmd.mod_last = 1'b1;
                    n_state      = S_BYTE;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            S_BYTE: begin
                cmd.byte_step = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (accept) begin
            cmd.load_in = 1'b1;
            if (!i_sts.key_ok) begin
                cmd.set_err = 1'b1;
                n_state     = S_DONE;
            end else if (i_op == OP_RESTART) begin
                cmd.seed_init = 1'b1;
                n_cnt         = '0;
                n_state       = S_SEED;
            end else if (i_sts.kidx_stale) begin
                cmd.mod_init = 1'b1;
                n_cnt        = POS_MSB;
                n_state      = S_MOD;
            end else begin
                n_state = S_BYTE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

FILE: src/dlx_dp.sv
// Datapath: key registers, seed hashing, LCG keystream, key-index remainder unit.
module dlx_dp
    import dlx_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  t_in_beat             i_in_beat,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output t_out_beat            o_out_beat
);

    localparam int unsigned KIDX_W = $clog2(MAX_KEY_BYTES);
    localparam logic [KLEN_W-1:0] MAX_LEN = KLEN_W'(MAX_KEY_BYTES);

    t_key              r_key;
    logic [KLEN_W-1:0] r_klen;
    logic [31:0]       r_lcg_a;
    logic [31:0]       r_lcg_b;
    logic [POS_W-1:0]  r_pos;
    logic [KIDX_W-1:0] r_kidx;
    logic              r_stale;
    logic [31:0]       r_sa;
    logic [31:0]       r_sb;
    logic [KLEN_W-1:0] r_rem;
    logic [7:0]        r_data;
    logic              r_last;
    t_out_beat         r_res;
    t_out_beat         r_out;

    logic [KLEN_W-1:0] klen_sat;
    logic [7:0]        kb_seed;
    logic [31:0]       sa_step;
    logic [31:0]       sb_step;
    logic [31:0]       mix_a;
    logic [31:0]       mix_b;
    logic [31:0]       lcg_a_nxt;
    logic [31:0]       lcg_b_nxt;
    logic [31:0]       pos_mix;
    logic [7:0]        kb_data;
    logic [31:0]       mixed;
    logic [7:0]        dout;
    logic [KLEN_W-1:0] kidx_inc;
    logic [KIDX_W-1:0] kidx_nxt;
    logic [KLEN_W:0]   rem_sh;
    logic [KLEN_W:0]   rem_nxt;

    always_comb begin
        klen_sat  = (r_klen > MAX_LEN) ? MAX_LEN : r_klen;

        kb_seed   = key_byte(r_key, i_cmd.idx[4:0]);
        sa_step   = 32'((r_sa ^ {24'd0, kb_seed}) * FNV_PRIME);
        sb_step   = {r_sb[26:0], 5'd0} + r_sb + {24'd0, kb_seed};

        mix_a     = {r_sa[18:0], r_sa[31:19]} ^ r_sb;
        mix_b     = {r_sb[14:0], r_sb[31:15]} + mix_a;

        lcg_a_nxt = 32'(r_lcg_a * LCG_A_MUL) + LCG_A_INC;
        lcg_b_nxt = 32'(r_lcg_b * LCG_B_MUL) + LCG_B_INC;
        pos_mix   = 32'(r_pos[31:0] * GOLDEN);
        kb_data   = key_byte(r_key, 5'(r_kidx));
        mixed     = lcg_a_nxt ^ {16'd0, lcg_b_nxt[31:16]} ^ {4{kb_data}} ^ pos_mix;
        dout      = r_data ^ mixed[31:24] ^ mixed[23:16] ^ mixed[15:8] ^ mixed[7:0];

        kidx_inc  = KLEN_W'(r_kidx) + 6'd1;
        kidx_nxt  = (kidx_inc == klen_sat) ? '0 : KIDX_W'(kidx_inc);

        rem_sh    = {r_rem, r_pos[i_cmd.idx]};
        rem_nxt   = (rem_sh >= {1'b0, klen_sat}) ? rem_sh - {1'b0, klen_sat} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_klen  <= '0;
            r_lcg_a <= '0;
            r_lcg_b <= '0;
            r_pos   <= '0;
            r_kidx  <= '0;
            r_stale <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_WORD_0: r_key[0] <= i_cfg_data;
                    CFG_KEY_WORD_1: r_key[1] <= i_cfg_data;
                    CFG_KEY_WORD_2: r_key[2] <= i_cfg_data;
                    CFG_KEY_WORD_3: r_key[3] <= i_cfg_data;
                    CFG_KEY_LENGTH: begin
                        r_klen  <= i_cfg_data[KLEN_W-1:0];
                        r_stale <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mix_last) begin
                r_lcg_a <= (mix_a == '0) ? SEED_A_ALT : mix_a;
                r_lcg_b <= (mix_b == '0) ? SEED_B_ALT : mix_b;
                r_pos   <= '0;
                r_kidx  <= '0;
                r_stale <= 1'b0;
            end
            if (i_cmd.mod_last) begin
                r_kidx  <= KIDX_W'(rem_nxt);
                r_stale <= 1'b0;
            end
            if (i_cmd.byte_step) begin
                r_lcg_a <= lcg_a_nxt;
                r_lcg_b <= lcg_b_nxt;
                r_pos   <= r_pos + 64'd1;
                r_kidx  <= (&r_pos) ? '0 : kidx_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_data <= i_in_beat.data_in;
            r_last <= i_in_beat.last_in;
        end
        if (i_cmd.seed_init) begin
            r_sa <= FNV_BASIS;
            r_sb <= DJB_BASIS;
        end
        if (i_cmd.seed_step) begin
            r_sa <= sa_step;
            r_sb <= sb_step;
        end
        if (i_cmd.mix_step) begin
            r_sa <= mix_a;
            r_sb <= mix_b;
        end
        if (i_cmd.mod_init) begin
            r_rem <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem <= rem_nxt[KLEN_W-1:0];
        end
        if (i_cmd.set_err) begin
            r_res.data_out        <= 8'd0;
            r_res.status          <= ST_BAD_KEY;
            r_res.stream_position <= r_pos;
            r_res.last_out        <= i_in_beat.last_in;
        end
        if (i_cmd.mix_last) begin
            r_res.data_out        <= 8'd0;
            r_res.status          <= ST_OK;
            r_res.stream_position <= '0;
            r_res.last_out        <= r_last;
        end
        if (i_cmd.byte_step) begin
            r_res.data_out        <= dout;
            r_res.status          <= ST_OK;
            r_res.stream_position <= r_pos + 64'd1;
            r_res.last_out        <= r_last;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.key_ok     = (klen_sat >= KEY_MIN_LEN);
    assign o_sts.key_len    = klen_sat;
    assign o_sts.kidx_stale = r_stale;
    assign o_out_beat       = r_out;

endmodule

FILE: src/dual_lcg_xor_stream_cipher.sv
// Top level of the dual-LCG XOR stream cipher: controller, datapath and ports.
//
//   Port        Dir   Kind          Contents
//   i_in        in    valid/ready   op, data_in, last_in
//   o_out       out   valid/ready   data_out, status, stream_position, last_out
//   i_cfg_*     in    write only    key_word_0..3, key_length
//
// A data beat is accepted, then both LCG multiplies and the position multiply
// run in one datapath step. A restart runs the one-byte-per-cycle hash walk
// over the key and four mixing rounds. The first data beat after a key_length
// write first runs the bit-serial position remainder. An invalid key goes from
// accept straight to the output state. Reset is synchronous and active low.
// A new beat is taken while a result waits in the output register.
module dual_lcg_xor_stream_cipher
    import dlx_pkg::*;
#(
    parameter int unsigned MAX_KEY_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    dlx_stream_if.sink           i_in,
    dlx_stream_if.source         o_out
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_in_beat  in_beat;
    t_out_beat out_beat;
    logic      in_ready;
    logic      out_valid;

    assign in_beat = i_in.payload;

    dlx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (in_beat.op),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dlx_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_beat  (in_beat),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_beat (out_beat)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_beat;

endmodule

FILE: tb/sv/tb_dual_lcg_xor_stream_cipher.sv
// Self-checking testbench for the dual-LCG XOR stream cipher with a keystream predictor.
module tb_dual_lcg_xor_stream_cipher;
    import dlx_pkg::*;

    localparam int unsigned RANDOM_BEATS = 1750;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 100;
    localparam int unsigned REPORT_MAX   = 10;

    class cipher_checker;
        logic [WORD_W-1:0] key_words [KEY_WORDS];
        logic [KLEN_W-1:0] key_len;
        logic [31:0]       lcg_a;
        logic [31:0]       lcg_b;
        logic [POS_W-1:0]  position;
        t_out_beat         awaited_results [$];
        int unsigned       mismatches;

        function new();
            foreach (key_words[i]) begin
                key_words[i] = '0;
            end
            key_len    = '0;
            lcg_a      = '0;
            lcg_b      = '0;
            position   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            case (idx)
                CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3: begin
                    key_words[idx] = value;
                end
                CFG_KEY_LENGTH: begin
                    key_len = value[KLEN_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function logic [7:0] key_at(int unsigned i);
            return key_words[(i / 8) % KEY_WORDS][(i % 8) * 8 +: 8];
        endfunction

        function void note_beat(t_in_beat b);
            int unsigned n;
            int unsigned i;
            logic [31:0] sa;
            logic [31:0] sb;
            logic [31:0] c;
            logic [7:0]  k;
            t_out_beat   r;
            n = (key_len > 32) ? 32 : key_len;
            r = '0;
            r.last_out = b.last_in;
            if (n < 4) begin
                r.status = ST_BAD_KEY;
            end else if (b.op == OP_RESTART) begin
                sa = 32'h811C9DC5;
                sb = 32'h00001505;
                for (i = 0; i < n; i++) begin
                    k  = key_at(i);
                    sa = (sa ^ {24'd0, k}) * 32'h01000193;
                    sb = sb * 32'd33 + {24'd0, k};
                end
                repeat (4) begin
                    sa = {sa[18:0], sa[31:19]} ^ sb;
                    sb = {sb[14:0], sb[31:15]} + sa;
                end
                lcg_a    = (sa == 32'd0) ? 32'h12345678 : sa;
                lcg_b    = (sb == 32'd0) ? 32'h9ABCDEF0 : sb;
                position = '0;
            end else begin
                lcg_a = lcg_a * 32'd1664525 + 32'd1013904223;
                lcg_b = lcg_b * 32'd22695477 + 32'd1;
                c  = lcg_a ^ (lcg_b >> 16);
                c ^= {4{key_at(int'(position % n))}};
                c ^= position[31:0] * 32'h9E3779B9;
                r.data_out = b.data_in ^ (c[31:24] ^ c[23:16] ^ c[15:8] ^ c[7:0]);
                position   = position + 64'd1;
            end
            r.stream_position = position;
            awaited_results.push_back(r);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected beat: data %02h status %0d position %0d last %0d",
                             got.data_out, got.status, got.stream_position, got.last_out);
                end
                return;
            end
            want = awaited_results.pop_front();
            if (got.data_out !== want.data_out || got.status !== want.status ||
                got.stream_position !== want.stream_position ||
                got.last_out !== want.last_out) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("beat mismatch: expected data %02h status %0d position %0d last %0d",
                             want.data_out, want.status, want.stream_position, want.last_out);
                    $display("                 actual data %02h status %0d position %0d last %0d",
                             got.data_out, got.status, got.stream_position, got.last_out);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [WORD_W-1:0]    i_cfg_data;

    dlx_stream_if #(.t_payload(t_in_beat))  in_ch ();
    dlx_stream_if #(.t_payload(t_out_beat)) out_ch ();

    cipher_checker cipher_ref;
    bit            tx_idle;
    bit            rx_idle;
    bit            hold_go;
    int unsigned   beats_sent;

    dual_lcg_xor_stream_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cipher_ref.write_reg(idx, value);
    endtask

    task automatic send_beat(logic code, logic [7:0] din, logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= t_in_beat'{op: code, data_in: din, last_in: last};
        do @(posedge i_clk); while (!in_ch.ready);
        cipher_ref.note_beat(in_ch.payload);
        beats_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (cipher_ref.awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_idle ? $urandom_range(0, 9) : 0;
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            cipher_ref.check_beat(out_ch.payload);
        end
    end

    initial begin : quiet_watch
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[dual_lcg_xor_stream_cipher] ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned       phase;
        int unsigned       phase_beats;
        int unsigned       r;
        int unsigned       len;
        bit                bad_key;
        logic [WORD_W-1:0] w;
        cipher_ref    = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        hold_go       = 1'b0;
        beats_sent    = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The key is invalid out of reset, so both operations must be refused.
        send_beat(OP_DATA, 8'hFF, 1'b1);
        send_beat(OP_RESTART, 8'h00, 1'b0);
        settle();
        cfg_write(CFG_KEY_WORD_0, '1);
        cfg_write(CFG_KEY_WORD_1, '0);
        cfg_write(CFG_KEY_WORD_2, 64'h0123456789ABCDEF);
        cfg_write(CFG_KEY_WORD_3, '1);
        cfg_write(CFG_KEY_LENGTH, 64'd63);
        send_beat(OP_DATA, 8'h00, 1'b0);
        send_beat(OP_DATA, 8'hFF, 1'b1);
        send_beat(OP_RESTART, 8'hFF, 1'b1);
        send_beat(OP_DATA, 8'h00, 1'b0);
        send_beat(OP_DATA, 8'hFF, 1'b0);
        send_beat(OP_DATA, 8'h5A, 1'b0);
        send_beat(OP_DATA, 8'hA5, 1'b1);
        settle();
        cfg_write(CFG_KEY_WORD_0, '0);
        cfg_write(CFG_KEY_WORD_1, '1);
        send_beat(OP_DATA, 8'h01, 1'b0);
        send_beat(OP_DATA, 8'h80, 1'b0);
        send_beat(OP_DATA, 8'h7F, 1'b1);
        settle();
        cfg_write(CFG_KEY_LENGTH, 64'd4);
        send_beat(OP_DATA, 8'h33, 1'b0);
        send_beat(OP_DATA, 8'hCC, 1'b0);
        send_beat(OP_RESTART, 8'h00, 1'b0);
        send_beat(OP_DATA, 8'h00, 1'b0);
        send_beat(OP_DATA, 8'hFF, 1'b1);
        settle();
        cfg_write(CFG_KEY_LENGTH, 64'd3);
        send_beat(OP_DATA, 8'hAA, 1'b1);
        send_beat(OP_RESTART, 8'h55, 1'b0);
        settle();
        cfg_write(CFG_KEY_LENGTH, 64'd32);
        send_beat(OP_DATA, 8'h12, 1'b0);
        send_beat(OP_RESTART, 8'h00, 1'b1);
        send_beat(OP_DATA, 8'hED, 1'b1);

        beats_sent = 0;
        phase      = 0;
        while (beats_sent < RANDOM_BEATS) begin
            settle();
            for (int unsigned i = 0; i < KEY_WORDS; i++) begin
                if (phase == 0 || $urandom_range(0, 9) < 7) begin
                    r = $urandom_range(0, 5);
                    w = (r == 0) ? '0 : (r == 1) ? '1 : {$urandom, $urandom};
                    cfg_write(CFG_KEY_WORD_0 + CFG_IDX_W'(i), w);
                end
            end
            if (phase == 0 || $urandom_range(0, 4) != 0) begin
                r   = $urandom_range(0, 19);
                len = (r == 0) ? $urandom_range(0, 3) :
                      (r <= 2) ? $urandom_range(33, 63) :
                      (r == 3) ? 32 : (r == 4) ? 4 : $urandom_range(4, 32);
                w = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
                w[KLEN_W-1:0] = KLEN_W'(len);
                cfg_write(CFG_KEY_LENGTH, w);
            end
            bad_key     = cipher_ref.key_len < 4;
            phase_beats = bad_key ? $urandom_range(5, 20) : $urandom_range(60, 160);
            tx_idle     = ($urandom_range(0, 3) != 0) && (phase % 4 != 1);
            rx_idle     = $urandom_range(0, 3) != 0;
            for (int unsigned i = 0; i < phase_beats; i++) begin
                if (phase % 4 == 1 && i == phase_beats / 2) begin
                    hold_go = 1'b1;
                end
                if (phase % 4 == 3 && i == phase_beats / 2) begin
                    settle();
                end
                if ((i == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 39) == 0) begin
                    send_beat(OP_RESTART, 8'($urandom), 1'($urandom));
                end else begin
                    send_beat(OP_DATA, 8'($urandom), $urandom_range(0, 3) == 0);
                end
            end
            phase++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cipher_ref.mismatches == 0 && cipher_ref.awaited_results.size() == 0) begin
            $display("[dual_lcg_xor_stream_cipher] OK");
        end else begin
            $display("[dual_lcg_xor_stream_cipher] ERROR");
        end
        $finish;
    end

endmodule
